/* hdl/i2e_pkg.sv */
package i2e_pkg;

  localparam logic [7:0] EscByte   = 8'h1b;
  localparam logic [7:0] HighBit   = 8'h80;
  localparam logic [7:0] SpaceByte = 8'h20;
  localparam logic [7:0] DelByte   = 8'h7f;
  localparam logic [7:0] ChDollar  = 8'h24;  // '$'
  localparam logic [7:0] ChParen   = 8'h28;  // '('
  localparam logic [7:0] ChB       = 8'h42;
  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChJ       = 8'h4a;
  localparam logic [7:0] ChH       = 8'h48;
  localparam logic [7:0] ChK       = 8'h4b;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    PhNormal    = 3'd0,
    PhEsc       = 3'd1,
    PhEscDollar = 3'd2,
    PhEscParen  = 3'd3,
    PhLead      = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_text;
  } out_word_t;

  typedef struct packed {
    logic [ResCntW-1:0]             cnt;
    out_word_t [MaxResults-1:0]     word;
  } push_t;

  function automatic logic is_control(input logic [7:0] c);
    return (c <= SpaceByte) || (c == DelByte);
  endfunction

endpackage

/* hdl/i2e_stream_if.sv */
interface i2e_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/i2e_convert.sv */
module i2e_convert import i2e_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  i2e_stream_if.sink in_i,
  input  logic  room_i,
  output push_t push_o
);

  phase_e     phase_q, phase_d;
  logic       kanji_q, kanji_d;
  logic [7:0] held_q, held_d;

  logic       accept;
  logic [7:0] c;
  logic       eot;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid && room_i;
  assign c          = in_i.data.in_byte;
  assign eot        = in_i.data.end_of_text;

  always_comb begin
    logic               fresh;
    logic [ResCntW-1:0] n;
    out_word_t [MaxResults-1:0] res;

    fresh   = 1'b0;
    n       = '0;
    res     = '0;
    phase_d = PhNormal;
    kanji_d = kanji_q;
    held_d  = held_q;

    unique case (phase_q)
      PhEsc: begin
        if (c == ChDollar) begin
          phase_d = PhEscDollar;
        end else if (c == ChParen) begin
          phase_d = PhEscParen;
        end else if (c == ChK) begin
          kanji_d = 1'b1;
        end else if (c == ChH) begin
          kanji_d = 1'b0;
        end else begin
          res[n] = '{EscByte, 1'b1, 1'b0}; n = n + ResCntW'(1);
          fresh  = 1'b1;
        end
      end
      PhEscDollar: begin
        if (c == ChB || c == ChAt) begin
          kanji_d = 1'b1;
        end else begin
          res[n] = '{EscByte, 1'b1, 1'b0};  n = n + ResCntW'(1);
          res[n] = '{ChDollar, 1'b1, 1'b0}; n = n + ResCntW'(1);
          fresh  = 1'b1;
        end
      end
      PhEscParen: begin
        if (c == ChJ || c == ChB || c == ChH) begin
          kanji_d = 1'b0;
        end else begin
          res[n] = '{EscByte, 1'b1, 1'b0}; n = n + ResCntW'(1);
          res[n] = '{ChParen, 1'b1, 1'b0}; n = n + ResCntW'(1);
          fresh  = 1'b1;
        end
      end
      PhLead: begin
        if (is_control(c)) begin
          res[n] = '{held_q, 1'b1, 1'b0}; n = n + ResCntW'(1);
          fresh  = 1'b1;
        end else begin
          res[n] = '{held_q | HighBit, 1'b1, 1'b0}; n = n + ResCntW'(1);
          res[n] = '{c | HighBit, 1'b1, 1'b0};      n = n + ResCntW'(1);
        end
        held_d = '0;
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      if (c == EscByte) begin
        phase_d = PhEsc;
      end else if (is_control(c)) begin
        res[n] = '{c, 1'b1, 1'b0}; n = n + ResCntW'(1);
      end else if (kanji_d) begin
        held_d  = c;
        phase_d = PhLead;
      end else begin
        res[n] = '{c, 1'b1, 1'b0}; n = n + ResCntW'(1);
      end
    end

    if (eot) begin
      unique case (phase_d)
        PhEsc: begin
          res[n] = '{EscByte, 1'b1, 1'b0}; n = n + ResCntW'(1);
        end
        PhEscDollar: begin
          res[n] = '{EscByte, 1'b1, 1'b0};  n = n + ResCntW'(1);
          res[n] = '{ChDollar, 1'b1, 1'b0}; n = n + ResCntW'(1);
        end
        PhEscParen: begin
          res[n] = '{EscByte, 1'b1, 1'b0}; n = n + ResCntW'(1);
          res[n] = '{ChParen, 1'b1, 1'b0}; n = n + ResCntW'(1);
        end
        PhLead: begin
          res[n] = '{held_d, 1'b1, 1'b0}; n = n + ResCntW'(1);
        end
        default: ;
      endcase
      if (n == '0) begin
        res[0] = '{8'h00, 1'b0, 1'b0};
        n      = ResCntW'(1);
      end
      res[n - ResCntW'(1)].last_of_text = 1'b1;
      phase_d = PhNormal;
      kanji_d = 1'b0;
      held_d  = '0;
    end

    push_o.word = res;
    push_o.cnt  = accept ? n : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      kanji_q <= 1'b0;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      kanji_q <= kanji_d;
      held_q  <= held_d;
    end
  end

endmodule

/* hdl/i2e_queue.sv */
module i2e_queue import i2e_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  i2e_stream_if.source out_o
);

  out_word_t mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign room_o     = cnt_q <= QCntW'(QueueDepth - MaxResults);
  assign out_o.valid = cnt_q != '0;
  assign out_o.data  = mem_q[rd_ptr_q];
  assign pop         = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    cnt_d    = cnt_q + QCntW'(push_i.cnt) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (ResCntW'(k) < push_i.cnt) begin
        mem_q[wr_ptr_q + QPtrW'(k)] <= push_i.word[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* hdl/iso2022jp_to_eucjp_stream.sv */
// Channel  Dir  Word fields                          Handshake
// in_i     in   in_byte[7:0], end_of_text            valid/ready
// out_o    out  out_byte[7:0], has_byte, last_of_text valid/ready
//
// One input word per cycle while in_i.ready is high; each yields 0..3 output words into an 8-entry queue.
// in_i.ready drops while fewer than 3 queue slots are free; output drains 1 word/cycle while out_o.ready is high.
// Results appear on out_o in the cycle after acceptance at the earliest.
// rst_ni is asynchronous: parser returns to ASCII mode, normal phase, queue empty.
module iso2022jp_to_eucjp_stream import i2e_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  i2e_stream_if.sink   in_i,
  i2e_stream_if.source out_o
);

  push_t push;
  logic  room;

  i2e_convert u_convert (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  i2e_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

/* bench/iso2022jp_to_eucjp_stream_tb.sv */
module iso2022jp_to_eucjp_stream_tb import i2e_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 4;
  localparam int CycleLimit = 500000;
  localparam int RandWords  = 410;

  typedef struct packed {
    in_word_t            w;
    logic                known;
    logic [1:0]          n;
    out_word_t [2:0]     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   mismatches  = 0;
  logic calm;

  i2e_stream_if #(.payload_t(in_word_t))  in_if ();
  i2e_stream_if #(.payload_t(out_word_t)) out_if ();

  iso2022jp_to_eucjp_stream DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  assign calm = (cycle_count[9:8] == 2'b11);

  // converter shadow state
  logic       kanji_on;
  phase_e     phase;
  logic [7:0] lead_byte;
  out_word_t  conv_out [3];
  int         conv_n;

  out_word_t  eucjp_expected [$];

  function automatic void put_byte(logic [7:0] b);
    if (conv_n < 3) begin
      conv_out[conv_n] = {b, 2'b10};
      conv_n++;
    end
  endfunction

  function automatic logic ctrl_byte(logic [7:0] c);
    return (c <= SpaceByte) || (c == DelByte);
  endfunction

  function automatic void take_fresh(logic [7:0] c);
    if (c == EscByte) begin
      phase = PhEsc;
    end else if (ctrl_byte(c)) begin
      put_byte(c);
    end else if (kanji_on) begin
      lead_byte = c;
      phase     = PhLead;
    end else begin
      put_byte(c);
    end
  endfunction

  function automatic void clear_converter();
    kanji_on  = 1'b0;
    phase     = PhNormal;
    lead_byte = 8'h00;
  endfunction

  function automatic void convert_word(in_word_t w);
    logic [7:0] c;
    c      = w.in_byte;
    conv_n = 0;
    case (phase)
      PhEsc: begin
        phase = PhNormal;
        if (c == ChDollar) phase = PhEscDollar;
        else if (c == ChParen) phase = PhEscParen;
        else if (c == ChK) kanji_on = 1'b1;
        else if (c == ChH) kanji_on = 1'b0;
        else begin
          put_byte(EscByte);
          take_fresh(c);
        end
      end
      PhEscDollar: begin
        phase = PhNormal;
        if (c == ChB || c == ChAt) begin
          kanji_on = 1'b1;
        end else begin
          put_byte(EscByte);
          put_byte(ChDollar);
          take_fresh(c);
        end
      end
      PhEscParen: begin
        phase = PhNormal;
        if (c == ChJ || c == ChB || c == ChH) begin
          kanji_on = 1'b0;
        end else begin
          put_byte(EscByte);
          put_byte(ChParen);
          take_fresh(c);
        end
      end
      PhLead: begin
        phase = PhNormal;
        if (ctrl_byte(c)) begin
          put_byte(lead_byte);
          take_fresh(c);
        end else begin
          put_byte(lead_byte | HighBit);
          put_byte(c | HighBit);
        end
        lead_byte = 8'h00;
      end
      default: begin
        phase = PhNormal;
        take_fresh(c);
      end
    endcase
    if (w.end_of_text) begin
      case (phase)
        PhEsc: put_byte(EscByte);
        PhEscDollar: begin
          put_byte(EscByte);
          put_byte(ChDollar);
        end
        PhEscParen: begin
          put_byte(EscByte);
          put_byte(ChParen);
        end
        PhLead: put_byte(lead_byte);
        default: ;
      endcase
      if (conv_n == 0) begin
        conv_out[0] = '0;
        conv_n      = 1;
      end
      conv_out[conv_n-1].last_of_text = 1'b1;
      clear_converter();
    end
  endfunction

  function automatic stim_row_t row_pred(logic [7:0] b, logic e);
    stim_row_t r;
    r         = '0;
    r.w       = {b, e};
    r.known   = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t row_known(logic [7:0] b, logic e, int n,
                                          out_word_t r0, out_word_t r1, out_word_t r2);
    stim_row_t r;
    r        = '0;
    r.w      = {b, e};
    r.known  = 1'b1;
    r.n      = n[1:0];
    r.res[0] = r0;
    r.res[1] = r1;
    r.res[2] = r2;
    return r;
  endfunction

  // mostly short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic deliver(stim_row_t r);
    int gap;
    gap = pick_pause();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= r.w;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    convert_word(r.w);
    if (r.known) begin
      for (int i = 0; i < r.n; i++) eucjp_expected.push_back(r.res[i]);
    end else begin
      for (int i = 0; i < conv_n; i++) eucjp_expected.push_back(conv_out[i]);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t got_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      got_w = out_if.data;
      if (eucjp_expected.size() == 0) begin
        $display("%0t: unexpected word, got byte %02h has %0b last %0b", $time,
                 got_w.out_byte, got_w.has_byte, got_w.last_of_text);
        mismatches++;
      end else begin
        exp_w = eucjp_expected.pop_front();
        if (got_w.out_byte !== exp_w.out_byte) begin
          $display("%0t: out_byte expected %02h got %02h", $time,
                   exp_w.out_byte, got_w.out_byte);
          mismatches++;
        end
        if (got_w.has_byte !== exp_w.has_byte) begin
          $display("%0t: has_byte expected %0b got %0b", $time,
                   exp_w.has_byte, got_w.has_byte);
          mismatches++;
        end
        if (got_w.last_of_text !== exp_w.last_of_text) begin
          $display("%0t: last_of_text expected %0b got %0b", $time,
                   exp_w.last_of_text, got_w.last_of_text);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_pause();
      end
    end
  end

  initial begin
    stim_row_t  directed [$];
    logic [7:0] burst [$];
    int         kind;
    int         len;
    int         sent;

    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    clear_converter();

    directed = {
      row_known(8'h41, 1'b0, 1, {8'h41, 2'b10}, '0, '0),
      row_known(8'hff, 1'b0, 1, {8'hff, 2'b10}, '0, '0),
      row_known(8'h00, 1'b0, 1, {8'h00, 2'b10}, '0, '0),
      row_known(EscByte, 1'b0, 0, '0, '0, '0),
      row_known(ChDollar, 1'b0, 0, '0, '0, '0),
      row_known(ChAt, 1'b0, 0, '0, '0, '0),
      row_pred(8'h21, 1'b0),
      row_pred(8'h7e, 1'b0),
      // lead then control byte
      row_known(8'h41, 1'b0, 0, '0, '0, '0),
      row_known(8'h0a, 1'b0, 2, {8'h41, 2'b10}, {8'h0a, 2'b10}, '0),
      // lead then ESC, leave kanji
      row_known(8'h50, 1'b0, 0, '0, '0, '0),
      row_known(EscByte, 1'b0, 1, {8'h50, 2'b10}, '0, '0),
      row_known(ChParen, 1'b0, 0, '0, '0, '0),
      row_known(ChJ, 1'b0, 0, '0, '0, '0),
      // broken ESC $
      row_known(EscByte, 1'b0, 0, '0, '0, '0),
      row_known(ChDollar, 1'b0, 0, '0, '0, '0),
      row_known(8'h78, 1'b0, 3, {EscByte, 2'b10}, {ChDollar, 2'b10}, {8'h78, 2'b10}),
      // unknown escape
      row_known(EscByte, 1'b0, 0, '0, '0, '0),
      row_known(8'h51, 1'b0, 2, {EscByte, 2'b10}, {8'h51, 2'b10}, '0),
      // ESC K, lead, DEL at end of text
      row_known(EscByte, 1'b0, 0, '0, '0, '0),
      row_known(ChK, 1'b0, 0, '0, '0, '0),
      row_known(8'h7a, 1'b0, 0, '0, '0, '0),
      row_known(DelByte, 1'b1, 2, {8'h7a, 2'b10}, {DelByte, 2'b11}, '0),
      // pending ESC ( flushed at end
      row_known(EscByte, 1'b0, 0, '0, '0, '0),
      row_known(ChParen, 1'b1, 2, {EscByte, 2'b10}, {ChParen, 2'b11}, '0),
      // end with nothing to emit
      row_known(EscByte, 1'b0, 0, '0, '0, '0),
      row_known(ChH, 1'b1, 1, {8'h00, 2'b01}, '0, '0)
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) deliver(directed[i]);

    sent = 0;
    while (sent < RandWords) begin
      burst.delete();
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        burst.push_back(EscByte);
        case ($urandom_range(0, 2))
          0: begin burst.push_back(ChDollar); burst.push_back(ChB); end
          1: begin burst.push_back(ChDollar); burst.push_back(ChAt); end
          default: burst.push_back(ChK);
        endcase
      end else if (kind < 40) begin
        burst.push_back(EscByte);
        case ($urandom_range(0, 3))
          0: begin burst.push_back(ChParen); burst.push_back(ChJ); end
          1: begin burst.push_back(ChParen); burst.push_back(ChB); end
          2: begin burst.push_back(ChParen); burst.push_back(ChH); end
          default: burst.push_back(ChH);
        endcase
      end else if (kind < 75) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) burst.push_back(8'($urandom_range(0, 255)));
          else burst.push_back(8'($urandom_range(8'h21, 8'h7e)));
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) burst.push_back(DelByte);
          else burst.push_back(8'($urandom_range(0, 8'h20)));
        end
      end else if (kind < 93) begin
        burst.push_back(EscByte);
        case ($urandom_range(0, 2))
          0: ;
          1: burst.push_back(ChDollar);
          default: burst.push_back(ChParen);
        endcase
        burst.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) burst.push_back(8'($urandom_range(0, 255)));
      end
      foreach (burst[i]) begin
        deliver(row_pred(burst[i], $urandom_range(0, 31) == 0));
        sent++;
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;

    while (eucjp_expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
